// ===== rtl/tspe_pkg.sv =====
package tspe_pkg;

  // Field widths fixed by the channel formats
  localparam int unsigned PosW      = 24;
  localparam int unsigned DurW      = 16;
  localparam int unsigned SndW      = 16;
  localparam int unsigned OutSlotW  = 3;
  localparam int unsigned MaxEvents = 8;
  localparam int unsigned EvCntW    = 4;

  localparam logic [DurW-1:0] DurMax = 16'hFFFF;

  typedef enum logic {
    OpTick = 1'b0,
    OpAdd  = 1'b1
  } op_e;

  typedef enum logic {
    EvPlay = 1'b0,
    EvStop = 1'b1
  } ev_kind_e;

  // One accepted request
  typedef struct packed {
    op_e                    op;
    logic signed [PosW-1:0] x;
    logic signed [PosW-1:0] y;
    logic signed [PosW-1:0] z;
    logic [DurW-1:0]        dur;
    logic [SndW-1:0]        sound;
    logic                   rep;
  } req_t;

  // One event before its last flag is known
  typedef struct packed {
    ev_kind_e               kind;
    logic [OutSlotW-1:0]    slot;
    logic [SndW-1:0]        sound;
    logic signed [PosW-1:0] x;
    logic signed [PosW-1:0] y;
    logic signed [PosW-1:0] z;
  } event_t;

  typedef struct packed {
    event_t ev;
    logic   last;
  } out_t;

  // Controller to datapath
  typedef struct packed {
    logic start;
    logic adv;
    logic evict_rd;
    logic evict_push;
    logic add_push;
    logic flush;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_add;
    logic ev_want;
    logic can_push;
    logic zero_hit;
    logic last_eval;
  } dp_sts_t;

endpackage

// ===== rtl/tspe_intf.sv =====
interface tspe_req_if;
  logic                             valid;
  logic                             ready;
  logic                             op;
  logic signed [tspe_pkg::PosW-1:0] pos_x;
  logic signed [tspe_pkg::PosW-1:0] pos_y;
  logic signed [tspe_pkg::PosW-1:0] pos_z;
  logic [tspe_pkg::DurW-1:0]        duration;
  logic [tspe_pkg::SndW-1:0]        sound_id;
  logic                             repeat_each_tick;

  modport source (
    output valid, op, pos_x, pos_y, pos_z, duration, sound_id, repeat_each_tick,
    input  ready
  );
  modport sink (
    input  valid, op, pos_x, pos_y, pos_z, duration, sound_id, repeat_each_tick,
    output ready
  );
endinterface

interface tspe_evt_if;
  logic                             valid;
  logic                             ready;
  logic                             event_kind;
  logic [tspe_pkg::OutSlotW-1:0]    slot_index;
  logic [tspe_pkg::SndW-1:0]        event_sound;
  logic signed [tspe_pkg::PosW-1:0] event_x;
  logic signed [tspe_pkg::PosW-1:0] event_y;
  logic signed [tspe_pkg::PosW-1:0] event_z;
  logic                             last_event;

  modport source (
    output valid, event_kind, slot_index, event_sound, event_x, event_y, event_z,
           last_event,
    input  ready
  );
  modport sink (
    input  valid, event_kind, slot_index, event_sound, event_x, event_y, event_z,
           last_event,
    output ready
  );
endinterface

// ===== rtl/tspe_ctrl.sv =====
module tspe_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tspe_pkg::dp_sts_t   sts_i,
  output tspe_pkg::ctrl_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StEvRd,
    StEvPush,
    StAddPush,
    StFlush
  } state_e;

  state_e state_q, state_d;

  // Sequencing of one transaction
  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    in_ready_o = (state_q == StIdle);
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = StScan;
        end
      end
      StScan: begin
        // hold the walk while an event cannot be parked
        cmd_o.adv = !(sts_i.ev_want && !sts_i.can_push);
        if (cmd_o.adv) begin
          if (sts_i.is_add && sts_i.zero_hit) begin
            state_d = StAddPush;
          end else if (sts_i.last_eval) begin
            state_d = sts_i.is_add ? StEvRd : StFlush;
          end
        end
      end
      StEvRd: begin
        cmd_o.evict_rd = 1'b1;
        state_d        = StEvPush;
      end
      StEvPush: begin
        if (sts_i.can_push) begin
          cmd_o.evict_push = 1'b1;
          state_d          = StAddPush;
        end
      end
      StAddPush: begin
        if (sts_i.can_push) begin
          cmd_o.add_push = 1'b1;
          state_d        = StFlush;
        end
      end
      StFlush: begin
        if (sts_i.can_push) begin
          cmd_o.flush = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/tspe_dp.sv =====
module tspe_dp #(
  parameter int unsigned SLOTS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tspe_pkg::req_t      req_i,
  input  tspe_pkg::ctrl_cmd_t cmd_i,
  output tspe_pkg::dp_sts_t   sts_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tspe_pkg::out_t      out_o
);

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CntW = $clog2(SLOTS + 1);

  typedef struct packed {
    logic [tspe_pkg::DurW-1:0]        ticks;
    logic signed [tspe_pkg::PosW-1:0] x;
    logic signed [tspe_pkg::PosW-1:0] y;
    logic signed [tspe_pkg::PosW-1:0] z;
    logic [tspe_pkg::SndW-1:0]        sound;
    logic                             rep;
  } slot_t;

  // Slot store, one read and one write port
  slot_t mem [SLOTS];
  logic [SLOTS-1:0] vld_q;

  tspe_pkg::req_t req_q;
  slot_t          rdata_q;
  logic           rvld_q;
  logic [IdxW-1:0] ridx_q;
  logic            eval_v_q;
  logic [CntW-1:0] cnt_q;
  logic [tspe_pkg::DurW-1:0] best_q;
  logic [IdxW-1:0]           tgt_q;
  logic [tspe_pkg::EvCntW-1:0] ev_cnt_q;
  logic                 pend_v_q;
  tspe_pkg::event_t     pend_q;
  logic                 out_v_q;
  tspe_pkg::out_t       out_q;

  logic                      is_add;
  logic [tspe_pkg::DurW-1:0] rticks;
  logic [tspe_pkg::DurW-1:0] new_ticks;
  logic                      more;
  logic                      room;
  logic                      rd_en;
  logic [IdxW-1:0]           raddr;
  logic                      we;
  logic [IdxW-1:0]           waddr;
  slot_t                     wdata;
  logic                      push_req;
  logic                      push_fire;
  tspe_pkg::event_t          push_ev;
  logic                      can_push;

  assign is_add    = (req_q.op == tspe_pkg::OpAdd);
  assign rticks    = rvld_q ? rdata_q.ticks : '0;
  assign new_ticks = rticks - 1'b1;
  assign more      = (cnt_q != CntW'(SLOTS));
  assign room      = (ev_cnt_q < tspe_pkg::EvCntW'(tspe_pkg::MaxEvents));
  assign can_push  = !pend_v_q || !out_v_q || out_ready_i;

  // Status towards the controller
  always_comb begin
    sts_o.is_add    = is_add;
    sts_o.ev_want   = !is_add && eval_v_q && (rticks != '0) &&
                      ((new_ticks == '0) || rdata_q.rep) && room;
    sts_o.can_push  = can_push;
    sts_o.zero_hit  = eval_v_q && (rticks == '0);
    sts_o.last_eval = eval_v_q && !more;
  end

  // Port selection and event building
  always_comb begin
    rd_en    = 1'b0;
    raddr    = cnt_q[IdxW-1:0];
    we       = 1'b0;
    waddr    = ridx_q;
    wdata    = rdata_q;
    push_req = 1'b0;
    push_ev  = '{kind: tspe_pkg::EvStop, slot: tspe_pkg::OutSlotW'(ridx_q),
                 sound: rdata_q.sound, x: rdata_q.x, y: rdata_q.y, z: rdata_q.z};
    if (cmd_i.adv) begin
      rd_en = more && !(is_add && sts_o.zero_hit);
      // tick: count down a busy slot and write it back
      if (!is_add && eval_v_q && (rticks != '0)) begin
        we          = 1'b1;
        wdata.ticks = new_ticks;
      end
      push_req = sts_o.ev_want;
      if (new_ticks != '0) begin
        push_ev.kind = tspe_pkg::EvPlay;
      end
    end
    if (cmd_i.evict_rd) begin
      rd_en = 1'b1;
      raddr = tgt_q;
    end
    if (cmd_i.evict_push) begin
      push_req     = 1'b1;
      push_ev.slot = tspe_pkg::OutSlotW'(tgt_q);
    end
    if (cmd_i.add_push) begin
      we       = 1'b1;
      waddr    = tgt_q;
      wdata    = '{ticks: req_q.dur, x: req_q.x, y: req_q.y, z: req_q.z,
                   sound: req_q.sound, rep: req_q.rep};
      push_req = 1'b1;
      push_ev  = '{kind: tspe_pkg::EvPlay, slot: tspe_pkg::OutSlotW'(tgt_q),
                   sound: req_q.sound, x: req_q.x, y: req_q.y, z: req_q.z};
    end
  end

  assign push_fire = push_req && room;

  // Memory array and registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem[raddr];
      ridx_q  <= raddr;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      req_q  <= req_i;
      best_q <= tspe_pkg::DurMax;
      tgt_q  <= '0;
    end else if (cmd_i.adv && is_add && eval_v_q) begin
      // first free slot wins, else strictly smallest countdown
      if (rticks == '0) begin
        tgt_q <= ridx_q;
      end else if (rticks < best_q) begin
        best_q <= rticks;
        tgt_q  <= ridx_q;
      end
    end
    if (push_fire) begin
      pend_q <= push_ev;
    end
    if ((push_fire || cmd_i.flush) && pend_v_q) begin
      out_q <= '{ev: pend_q, last: cmd_i.flush};
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rvld_q   <= 1'b0;
      eval_v_q <= 1'b0;
      cnt_q    <= '0;
      ev_cnt_q <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (we) begin
        vld_q[waddr] <= 1'b1;
      end
      if (rd_en) begin
        rvld_q <= vld_q[raddr];
      end
      if (cmd_i.start) begin
        eval_v_q <= 1'b0;
        cnt_q    <= '0;
        ev_cnt_q <= '0;
      end else begin
        if (cmd_i.adv) begin
          eval_v_q <= rd_en;
          if (rd_en) begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        if (push_fire) begin
          ev_cnt_q <= ev_cnt_q + 1'b1;
        end
      end
      // parked event moves out when a newer one arrives or on flush
      if ((push_fire || cmd_i.flush) && pend_v_q) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
      if (push_fire) begin
        pend_v_q <= 1'b1;
      end else if (cmd_i.flush) begin
        pend_v_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign out_o       = out_q;

`ifndef SYNTH
  // write-back never collides with the slot being fetched
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we && rd_en) |-> (waddr != raddr))
    else $error("slot write and read at the same address");

  // displacing a parked event always fills the output register
  a_park_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_fire && pend_v_q) |=> out_v_q)
    else $error("parked event lost");

  // slot valid bits are only ever set after reset
  a_vld_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((vld_q & $past(vld_q)) == $past(vld_q)))
    else $error("slot valid bit cleared");
`endif

endmodule

// ===== rtl/timed_slot_pool_evict_min_top.sv =====
// Timed slot pool with least-remaining eviction.
// in_i takes one request per transaction: op 0 is a tick, op 1 adds a timed
// source. out_o gives the events each request causes, last_event set on the
// final one; a tick may cause none, an add gives one or two (stop of the
// evicted slot, then play of the new one). At most eight events per request.
// The slots live in a memory with one read and one write port, walked one
// slot per cycle by a controller while each due event can be parked; how long
// a request takes is set by that walk: a tick walks every slot, an add stops
// at the first free slot, else walks them all and then evicts. A tick's
// earlier events leave while the walk still runs; the last event appears
// once the walk ends. Requests are taken one at a time; in_i.ready is high
// between them, also while the last event still waits on out_o.
// When out_o stalls, one event waits in the output register and one more is
// parked; the walk then pauses until room frees up, nothing is dropped.
// Reset marks every slot free; no clearing pass is needed and the block
// is ready as soon as reset is released.
module timed_slot_pool_evict_min_top #(
  parameter int unsigned SLOTS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tspe_req_if.sink   in_i,
  tspe_evt_if.source out_o
);

  tspe_pkg::req_t      req;
  tspe_pkg::ctrl_cmd_t cmd;
  tspe_pkg::dp_sts_t   sts;
  tspe_pkg::out_t      evt;
  logic                in_ready;
  logic                out_valid;

  // Request payload
  always_comb begin
    req.op    = tspe_pkg::op_e'(in_i.op);
    req.x     = in_i.pos_x;
    req.y     = in_i.pos_y;
    req.z     = in_i.pos_z;
    req.dur   = in_i.duration;
    req.sound = in_i.sound_id;
    req.rep   = in_i.repeat_each_tick;
  end

  assign in_i.ready = in_ready;

  tspe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tspe_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .out_o       (evt)
  );

  // Event payload
  assign out_o.valid       = out_valid;
  assign out_o.event_kind  = evt.ev.kind;
  assign out_o.slot_index  = evt.ev.slot;
  assign out_o.event_sound = evt.ev.sound;
  assign out_o.event_x     = evt.ev.x;
  assign out_o.event_y     = evt.ev.y;
  assign out_o.event_z     = evt.ev.z;
  assign out_o.last_event  = evt.last;

endmodule
